FILE: rtl/core/sftr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sftr_pkg
// Shared types, register codes and the 5x7 font table of the text rasterizer.
// ----------------------------------------------------------------------------
package sftr_pkg;

  localparam int GLYPH_COUNT  = 95;
  localparam int GLYPH_BITS   = 35;
  localparam int GLYPH_ROWS   = 7;
  localparam int GLYPH_COLS   = 5;
  localparam logic [7:0] FIRST_CODE    = 8'h20;
  localparam logic [7:0] LAST_CODE     = 8'h7E;
  localparam logic [7:0] FALLBACK_CODE = 8'h3F;
  localparam logic [10:0] COORD_LIMIT  = 11'd1024;

  localparam logic REG_FB_WIDTH  = 1'b0;
  localparam logic REG_FB_HEIGHT = 1'b1;

  typedef struct packed {
    logic       hit;
    logic [9:0] x;
    logic [9:0] y;
    logic [3:0] w;
    logic [3:0] h;
  } cell_t;

  // columns 0..4 from left to right, bit 0 of each byte is the top row
  localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00,
    40'h14_7F_14_7F_14, 40'h24_2A_7F_2A_12, 40'h23_13_08_64_62,
    40'h36_49_55_22_50, 40'h00_05_03_00_00, 40'h00_1C_22_41_00,
    40'h00_41_22_1C_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00,
    40'h20_10_08_04_02, 40'h3E_51_49_45_3E, 40'h00_42_7F_40_00,
    40'h42_61_51_49_46, 40'h21_41_45_4B_31, 40'h18_14_12_7F_10,
    40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00,
    40'h00_56_36_00_00, 40'h00_08_14_22_41, 40'h14_14_14_14_14,
    40'h41_22_14_08_00, 40'h02_01_51_09_06, 40'h32_49_79_41_3E,
    40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01,
    40'h3E_41_41_51_32, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00,
    40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
    40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46,
    40'h46_49_49_49_31, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F,
    40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F, 40'h63_14_08_14_63,
    40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_00_7F_41_41,
    40'h02_04_08_10_20, 40'h41_41_7F_00_00, 40'h04_02_01_02_04,
    40'h40_40_40_40_40, 40'h00_01_02_04_00, 40'h20_54_54_54_78,
    40'h7F_48_44_44_38, 40'h38_44_44_44_20, 40'h38_44_44_48_7F,
    40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_14_54_54_3C,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00,
    40'h00_7F_10_28_44, 40'h00_41_7F_40_00, 40'h7C_04_18_04_78,
    40'h7C_08_04_04_78, 40'h38_44_44_44_38, 40'h7C_14_14_14_08,
    40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C,
    40'h3C_40_30_40_3C, 40'h44_28_10_28_44, 40'h0C_50_50_50_3C,
    40'h44_64_54_4C_44, 40'h00_08_36_41_00, 40'h00_00_7F_00_00,
    40'h00_41_36_08_00, 40'h08_08_2A_1C_08
  };

  // scan order: column-major, bit 7*col+row
  function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [6:0] idx);
    logic [GLYPH_BITS-1:0] g;
    g = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      g[c*GLYPH_ROWS +: GLYPH_ROWS] = FONT_ROM[idx][32-8*c +: GLYPH_ROWS];
    end
    return g;
  endfunction

endpackage

FILE: rtl/core/scaled_font_text_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_font_text_rasterizer
// Turns text characters into clipped fill rectangles from a 5x7 font.
// Each character takes an accept step, a scan of its 35 glyph cells (one glyph
// cell per cycle through the shared clip unit, while the result side does not
// stall) and a flush step. A rectangle is held in a pending register and moves
// to the output register when the next lit cell is scanned, the last one in
// the flush state.
// Synchronous reset clears pen to zero and framebuffer size to 240x240.
// ----------------------------------------------------------------------------
module scaled_font_text_rasterizer
  import sftr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], start_x[19:8], start_y[31:20], scale[35:32],
  // ink_color[51:36], zero pad[55:52]
  input  logic [55:0] s_axis_tdata,
  // new_string[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cell_x[9:0], cell_y[19:10], cell_width[23:20], cell_height[27:24],
  // fill_color[43:28], zero pad[47:44]
  output logic [47:0] m_axis_tdata,
  // last_cell
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t                state;
  logic [10:0]           fb_width, fb_height;
  logic [15:0]           pen_x, pen_y;
  logic [15:0]           base_x, base_y;
  logic [GLYPH_BITS-1:0] glyph;
  logic [2:0]            scan_column, scan_row;
  logic [5:0]            off_x;
  logic [6:0]            off_y;
  logic [3:0]            sc;
  logic [15:0]           color;
  logic                  pend_valid;
  cell_t                 pend;
  logic                  out_valid;
  cell_t                 out_cell;
  logic [15:0]           out_color;
  logic                  out_last;

  logic [7:0]  in_code;
  logic [15:0] in_sx, in_sy, in_base_x, in_base_y;
  logic [3:0]  in_sc;
  logic [6:0]  in_adv;
  logic [16:0] in_nx;
  logic [15:0] in_pen_next;
  logic [6:0]  in_idx;
  logic [7:0]  in_glyph_code;
  logic [10:0] lim_w, lim_h;
  cell_t       clip_rect;
  logic        out_free, cell_hit, out_load;

  always_comb begin
    in_code       = s_axis_tdata[7:0];
    in_sx         = {{4{s_axis_tdata[19]}}, s_axis_tdata[19:8]};
    in_sy         = {{4{s_axis_tdata[31]}}, s_axis_tdata[31:20]};
    in_sc         = (s_axis_tdata[35:32] == 4'd0) ? 4'd1 : s_axis_tdata[35:32];
    in_base_x     = s_axis_tuser ? in_sx : pen_x;
    in_base_y     = s_axis_tuser ? in_sy : pen_y;
    in_adv        = {1'b0, in_sc, 2'b00} + {2'b00, in_sc, 1'b0};
    in_nx         = {in_base_x[15], in_base_x} + {10'd0, in_adv};
    in_pen_next   = (!in_nx[16] && in_nx[15]) ? 16'h7FFF : in_nx[15:0];
    in_glyph_code = (in_code < FIRST_CODE || in_code > LAST_CODE) ? FALLBACK_CODE
                                                                  : in_code;
    in_idx        = 7'(in_glyph_code - FIRST_CODE);
    lim_w         = (fb_width > COORD_LIMIT) ? COORD_LIMIT : fb_width;
    lim_h         = (fb_height > COORD_LIMIT) ? COORD_LIMIT : fb_height;
    out_free      = !out_valid || m_axis_tready;
    cell_hit      = glyph[0] && clip_rect.hit;
    out_load      = pend_valid && out_free &&
                    (((state == ST_SCAN) && cell_hit) || (state == ST_FLUSH));
  end

  sftr_cell_clip u_clip (
    .base_x (base_x),
    .base_y (base_y),
    .off_x  (off_x),
    .off_y  (off_y),
    .scale  (sc),
    .lim_w  (lim_w),
    .lim_h  (lim_h),
    .rect   (clip_rect)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width  <= 11'd240;
      fb_height <= 11'd240;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FB_WIDTH:  fb_width  <= cfg_data;
        REG_FB_HEIGHT: fb_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pen_x       <= '0;
      pen_y       <= '0;
      scan_column <= '0;
      scan_row    <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_cell  <= pend;
        out_color <= color;
        out_last  <= (state == ST_FLUSH);
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            base_x      <= in_base_x;
            base_y      <= in_base_y;
            pen_x       <= in_pen_next;
            pen_y       <= in_base_y;
            sc          <= in_sc;
            color       <= s_axis_tdata[51:36];
            glyph       <= font_glyph(in_idx);
            scan_column <= '0;
            scan_row    <= '0;
            off_x       <= '0;
            off_y       <= '0;
            state       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!(cell_hit && pend_valid && !out_free)) begin
            if (cell_hit) begin
              pend       <= clip_rect;
              pend_valid <= 1'b1;
            end
            glyph <= glyph >> 1;
            if (scan_row == 3'(GLYPH_ROWS - 1)) begin
              scan_row <= '0;
              off_y    <= '0;
              off_x    <= off_x + {2'b00, sc};
              if (scan_column == 3'(GLYPH_COLS - 1)) begin
                scan_column <= '0;
                state       <= ST_FLUSH;
              end else begin
                scan_column <= scan_column + 3'd1;
              end
            end else begin
              scan_row <= scan_row + 3'd1;
              off_y    <= off_y + {3'b000, sc};
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {4'd0, out_color, out_cell.h, out_cell.w, out_cell.y, out_cell.x};

endmodule

FILE: rtl/core/sftr_cell_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sftr_cell_clip
// Clips one scale-by-scale glyph cell against the framebuffer on both axes.
// ----------------------------------------------------------------------------
module sftr_cell_clip
  import sftr_pkg::*;
(
  input  logic [15:0] base_x,
  input  logic [15:0] base_y,
  input  logic [5:0]  off_x,
  input  logic [6:0]  off_y,
  input  logic [3:0]  scale,
  input  logic [10:0] lim_w,
  input  logic [10:0] lim_h,
  output cell_t       rect
);

  logic signed [17:0] lo_x, hi_x, a_x, b_x, w_x, lm_x;
  logic signed [17:0] lo_y, hi_y, a_y, b_y, w_y, lm_y;

  always_comb begin
    lo_x = {{2{base_x[15]}}, base_x} + {12'd0, off_x};
    hi_x = lo_x + {14'd0, scale};
    lm_x = {7'd0, lim_w};
    a_x  = lo_x[17] ? 18'sd0 : lo_x;
    b_x  = (hi_x > lm_x) ? lm_x : hi_x;
    w_x  = b_x - a_x;

    lo_y = {{2{base_y[15]}}, base_y} + {11'd0, off_y};
    hi_y = lo_y + {14'd0, scale};
    lm_y = {7'd0, lim_h};
    a_y  = lo_y[17] ? 18'sd0 : lo_y;
    b_y  = (hi_y > lm_y) ? lm_y : hi_y;
    w_y  = b_y - a_y;

    rect.hit = (b_x > a_x) && (b_y > a_y);
    rect.x   = a_x[9:0];
    rect.y   = a_y[9:0];
    rect.w   = w_x[3:0];
    rect.h   = w_y[3:0];
  end

endmodule

FILE: verif/sftr_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sftr_tb_pkg
// Glyph raster model and rectangle checker for the text rasterizer bench.
// Tracks pen position and framebuffer size, expands each accepted character
// into its clipped fill rectangles and compares the block's output, one field
// at a time, against the oldest pending rectangle.
// ----------------------------------------------------------------------------
package sftr_tb_pkg;
  import sftr_pkg::*;

  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [3:0]  w;
    logic [3:0]  h;
    logic [15:0] color;
    logic        last;
  } fill_rect_t;

  class glyph_raster_model;
    int unsigned fb_w;
    int unsigned fb_h;
    int          pen_x;
    int          pen_y;
    int          errors;
    fill_rect_t  expected_rects[$];

    function new();
      fb_w   = 240;
      fb_h   = 240;
      pen_x  = 0;
      pen_y  = 0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [10:0] val);
      if (idx == REG_FB_WIDTH) begin
        fb_w = val;
      end else begin
        fb_h = val;
      end
    endfunction

    function int clip_span(int lo, int len, int lim, output int start);
      int a;
      int b;
      a = (lo < 0) ? 0 : lo;
      b = lo + len;
      if (b > lim) b = lim;
      start = a;
      return (b > a) ? b - a : 0;
    endfunction

    // expand one accepted character into its rectangles and advance the pen
    function void add_char(logic [55:0] d, logic new_str);
      logic [7:0] code;
      logic [7:0] col_bits;
      logic [15:0] ink;
      int sc;
      int limw;
      int limh;
      int cx;
      int cy;
      int w;
      int h;
      int nx;
      int first;
      fill_rect_t rect;
      code = d[7:0];
      sc   = d[35:32];
      ink  = d[51:36];
      limw = (fb_w > int'(COORD_LIMIT)) ? int'(COORD_LIMIT) : int'(fb_w);
      limh = (fb_h > int'(COORD_LIMIT)) ? int'(COORD_LIMIT) : int'(fb_h);
      if (new_str) begin
        pen_x = $signed(d[19:8]);
        pen_y = $signed(d[31:20]);
      end
      if (sc == 0) sc = 1;
      if (code != FIRST_CODE) begin
        if (code < FIRST_CODE || code > LAST_CODE) code = FALLBACK_CODE;
        first = expected_rects.size();
        for (int c = 0; c < GLYPH_COLS; c++) begin
          col_bits = FONT_ROM[code - FIRST_CODE][32-8*c +: 8];
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            if (col_bits[r]) begin
              w = clip_span(pen_x + c * sc, sc, limw, cx);
              h = clip_span(pen_y + r * sc, sc, limh, cy);
              if (w > 0 && h > 0) begin
                rect.x     = cx[9:0];
                rect.y     = cy[9:0];
                rect.w     = w[3:0];
                rect.h     = h[3:0];
                rect.color = ink;
                rect.last  = 1'b0;
                expected_rects.push_back(rect);
              end
            end
          end
        end
        if (expected_rects.size() > first) begin
          rect = expected_rects.pop_back();
          rect.last = 1'b1;
          expected_rects.push_back(rect);
        end
      end
      nx = pen_x + 6 * sc;
      if (nx > 32767) nx = 32767;
      if (nx < -32768) nx = -32768;
      pen_x = nx;
    endfunction

    function void compare(string field, int expv, int actv);
      if (expv != actv) begin
        errors++;
        $display("%0t mismatch %s: expected %0h, got %0h", $time, field, expv, actv);
      end
    endfunction

    function void check_rect(logic [47:0] d, logic last);
      fill_rect_t e;
      if (expected_rects.size() == 0) begin
        errors++;
        $display("%0t unexpected rect: expected none, got %h last %b", $time, d, last);
        return;
      end
      e = expected_rects.pop_front();
      compare("cell_x", e.x, d[9:0]);
      compare("cell_y", e.y, d[19:10]);
      compare("cell_width", e.w, d[23:20]);
      compare("cell_height", e.h, d[27:24]);
      compare("fill_color", e.color, d[43:28]);
      compare("last_cell", e.last, last);
    endfunction
  endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the scaled font text rasterizer.
// Feeds directed characters (range edges, fallback glyph, space, clipping on
// every side, zero and oversized framebuffers, a long run of wide spaces) and
// then random strings under several framebuffer sizes, with random idling on
// both sides and one long output hold-off. Every rectangle is checked against
// the model.
// ----------------------------------------------------------------------------
module tb_top;
  import sftr_pkg::*;
  import sftr_tb_pkg::*;

  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic        cfg_index     = 1'b0;
  logic [10:0] cfg_data      = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  glyph_raster_model raster;
  bit src_gaps  = 1'b1;
  bit snk_gaps  = 1'b1;
  bit stall_req = 1'b0;
  int stall_left;

  scaled_font_text_rasterizer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // check accepted rectangles, then pick tready for the next cycle
  initial begin
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        raster.check_rect(m_axis_tdata, m_axis_tlast);
      end
      if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !snk_gaps || ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic send_char(input logic [7:0] code, input logic [11:0] sx,
                           input logic [11:0] sy, input logic new_str,
                           input logic [3:0] scale, input logic [15:0] ink);
    logic [55:0] d;
    d = {4'h0, ink, scale, sy, sx, code};
    if (src_gaps && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= new_str;
    do @(posedge clk); while (!s_axis_tready);
    raster.add_char(d, new_str);
  endtask

  // drop valid, wait for all rectangles, then let the scan finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (raster.expected_rects.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_fb(input logic [10:0] w, input logic [10:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FB_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    raster.write_reg(REG_FB_WIDTH, w);
    cfg_index <= REG_FB_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    raster.write_reg(REG_FB_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // one string: new_string on the first character in most strings, mostly printable text
  task automatic send_string(output int sent);
    int n;
    int lim_w;
    int lim_h;
    logic [11:0] sx;
    logic [11:0] sy;
    logic [3:0] sc;
    logic [15:0] ink;
    logic [7:0] code;
    logic new_str;
    n     = $urandom_range(1, 8);
    lim_w = raster.fb_w;
    lim_h = raster.fb_h;
    if ($urandom_range(9) == 0) begin
      sx = 12'($urandom);
      sy = 12'($urandom);
    end else begin
      sx = 12'(int'($urandom_range(0, lim_w + 40)) - 20);
      sy = 12'(int'($urandom_range(0, lim_h + 40)) - 20);
    end
    sc  = ($urandom_range(9) < 7) ? 4'($urandom_range(0, 4)) : 4'($urandom);
    ink = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0:       code = 8'($urandom);
        1:       code = FIRST_CODE;
        default: code = 8'($urandom_range(8'h21, 8'h7E));
      endcase
      new_str = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
      if (i == 0 || new_str) begin
        send_char(code, sx, sy, new_str, sc, ink);
      end else begin
        send_char(code, 12'($urandom), 12'($urandom), new_str, sc, ink);
      end
      if ($urandom_range(9) == 0) sc = 4'($urandom);
    end
    sent = n;
  endtask

  task automatic random_phase(input int items);
    int sent;
    int k;
    sent = 0;
    while (sent < items) begin
      send_string(k);
      sent += k;
    end
  endtask

  initial begin
    raster = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default 240x240 geometry
    send_char(8'h41, 12'd0, 12'd0, 1'b1, 4'd1, 16'hFFFF);
    send_char(8'h41, 12'd0, 12'd0, 1'b0, 4'd0, 16'h0000);
    send_char(8'h7E, 12'd10, 12'd20, 1'b1, 4'd15, 16'h8421);
    send_char(8'h21, 12'd0, 12'd0, 1'b0, 4'd2, 16'h1234);
    send_char(FIRST_CODE, 12'd0, 12'd0, 1'b0, 4'd3, 16'h5555);
    send_char(8'h00, 12'd0, 12'd0, 1'b0, 4'd1, 16'hAAAA);
    send_char(8'hFF, 12'd230, 12'd100, 1'b1, 4'd3, 16'h7BEF);
    send_char(8'h7F, -12'sd7, -12'sd3, 1'b1, 4'd4, 16'hF800);
    send_char(8'h1F, 12'd0, 12'd0, 1'b0, 4'd4, 16'h07E0);
    send_char(8'h23, 12'h800, 12'h800, 1'b1, 4'd15, 16'h001F);
    send_char(8'h40, 12'h7FF, 12'h7FF, 1'b1, 4'd15, 16'hFFE0);
    send_char(8'h4D, 12'd235, 12'd236, 1'b1, 4'd3, 16'h0F0F);
    send_char(8'h38, 12'd0, -12'sd20, 1'b1, 4'd15, 16'hF0F0);
    send_char(8'h57, -12'sd60, 12'd0, 1'b1, 4'd15, 16'h3C3C);
    send_char(8'h5F, 12'd0, 12'd0, 1'b1, 4'd1, 16'hC3C3);
    settle();

    set_fb(11'd0, 11'd240);
    send_char(8'h45, 12'd0, 12'd0, 1'b1, 4'd15, 16'h1111);
    settle();
    set_fb(11'd240, 11'd0);
    send_char(8'h45, 12'd0, 12'd0, 1'b1, 4'd1, 16'h2222);
    settle();
    set_fb(11'd1, 11'd1);
    send_char(8'h45, 12'd0, 12'd0, 1'b1, 4'd15, 16'h3333);
    send_char(8'h45, -12'sd14, -12'sd14, 1'b1, 4'd15, 16'h4444);
    settle();
    set_fb(11'd2047, 11'd2047);
    send_char(8'h57, 12'd1020, 12'd1015, 1'b1, 4'd15, 16'h6666);
    send_char(8'h42, 12'd1023, 12'd1023, 1'b1, 4'd1, 16'h7777);
    settle();
    set_fb(11'd1024, 11'd1024);
    send_char(8'h48, 12'd1010, 12'd1010, 1'b1, 4'd2, 16'hA5A5);
    settle();

    // advance the pen far with wide spaces
    src_gaps = 1'b0;
    send_char(FIRST_CODE, 12'h7FF, 12'd0, 1'b1, 4'd15, 16'h0000);
    repeat (20) send_char(FIRST_CODE, 12'($urandom), 12'($urandom), 1'b0, 4'd15,
                          16'($urandom));
    send_char(8'h48, 12'd0, 12'd0, 1'b0, 4'd15, 16'hBEEF);
    send_char(8'h69, 12'd0, 12'd0, 1'b0, 4'd0, 16'hCAFE);
    send_char(8'h41, 12'd0, 12'd0, 1'b1, 4'd1, 16'hD00D);
    settle();
    src_gaps = 1'b1;

    set_fb(11'd240, 11'd240);
    random_phase(24);
    settle();

    // no idling; long output hold-off so the block backs up
    src_gaps  = 1'b0;
    snk_gaps  = 1'b0;
    set_fb(11'd1024, 11'd1024);
    stall_req = 1'b1;
    random_phase(24);
    settle();
    src_gaps = 1'b1;
    snk_gaps = 1'b1;

    set_fb(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
    random_phase(24);
    settle();
    set_fb(11'd2047, 11'd17);
    random_phase(24);
    settle();
    set_fb(11'd13, 11'd2047);
    random_phase(24);
    settle();

    if (raster.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sftr_pkg.sv
rtl/core/sftr_cell_clip.sv
rtl/core/scaled_font_text_rasterizer.sv
verif/sftr_tb_pkg.sv
verif/tb_top.sv
